FILE: rtl/core/fvg_pkg.sv
// shared constants, types and helpers for the fat volume geometry block
// no dependencies
package fvg_pkg;

  localparam int MAX_ALIGN_TRIES = 16;

  localparam logic [31:0] FAT12_LIMIT = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT = 32'd65525;
  localparam logic [19:0] ROOT_BYTES  = 20'd16384;
  localparam logic [12:0] SECT_MIN    = 13'd512;
  localparam logic [12:0] SECT_MAX    = 13'd4096;
  localparam logic [6:0]  RES_FAT12   = 7'd2;
  localparam logic [6:0]  RES_FAT32   = 7'd32;
  localparam logic [6:0]  RES_LIMIT   = 7'(31 + MAX_ALIGN_TRIES);
  localparam logic [3:0]  MUL_STEPS   = 4'd13;
  localparam logic [5:0]  DIV_STEPS   = 6'd32;

  typedef enum logic [1:0] {
    FAT12 = 2'd0,
    FAT16 = 2'd1,
    FAT32 = 2'd2
  } fat_kind_t;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MUL    = 11'b000_0000_0010,
    S_CSDIV  = 11'b000_0000_0100,
    S_ROOT   = 11'b000_0000_1000,
    S_CNT    = 11'b000_0001_0000,
    S_F12    = 11'b000_0010_0000,
    S_F16    = 11'b000_0100_0000,
    S_F32CNT = 11'b000_1000_0000,
    S_F32LEN = 11'b001_0000_0000,
    S_SUB    = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  // default cluster bytes from the volume size in bytes
  function automatic logic [31:0] dflt_cluster_bytes(input logic [44:0] vol);
    logic [31:0] r;
    begin
      if (|vol[44:41])      r = 32'd262144;
      else if (|vol[44:39]) r = 32'd131072;
      else if (|vol[44:37]) r = 32'd65536;
      else if (|vol[44:36]) r = 32'd32768;
      else if (|vol[44:35]) r = 32'd16384;
      else if (|vol[44:34]) r = 32'd8192;
      else if (|vol[44:29]) r = 32'd4096;
      else if (|vol[44:28]) r = 32'd2048;
      else if (|vol[44:20]) r = 32'd1024;
      else                  r = 32'd512;
      return r;
    end
  endfunction

endpackage

FILE: rtl/core/fat_volume_geometry.sv
// sequence: a shift-add size product, then a chain of bit-serial divisions, then the
//   load of the output register; 4 to 6 divisions plus 2 per fat32 alignment try
// throughput: one item at a time; the next item is taken the cycle after the result
//   moves to the output register, even while that result still waits there
// reset: synchronous active-low rst_n idles the sequencer and divider and clears out_valid
// depends on fvg_pkg
module fat_volume_geometry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_total_sectors,
  input  logic [12:0] in_sector_bytes,
  input  logic [7:0]  in_cluster_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_fat_type,
  output logic [7:0]  out_cluster_sectors,
  output logic [6:0]  out_reserved_sectors,
  output logic [19:0] out_root_dir_bytes,
  output logic [31:0] out_cluster_count,
  output logic [31:0] out_fat_sectors,
  output logic [15:0] out_short_total_sectors,
  output logic [31:0] out_long_total_sectors,
  output logic        out_align_exhausted
);

  fvg_pkg::state_t state_r, state_nxt;

  logic [31:0] total_r, total_nxt;
  logic [12:0] ss_r, ss_nxt;
  logic [7:0]  csr_r, csr_nxt;
  logic [7:0]  cs_r, cs_nxt;
  logic [44:0] vol_r, vol_nxt;
  logic [12:0] msh_r, msh_nxt;
  logic [3:0]  mcnt_r, mcnt_nxt;
  logic        small_r, small_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] flen_r, flen_nxt;
  logic [6:0]  res_r, res_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [19:0] root_r, root_nxt;
  logic        flag_r, flag_nxt;

  // bit-serial restoring divider
  logic [31:0] dq_r, dq_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [12:0] dv_r, dv_nxt;
  logic [5:0]  dcnt_r, dcnt_nxt;
  logic        div_done;
  logic [13:0] dtry;
  logic        ld;
  logic [31:0] ld_a;
  logic [12:0] ld_b;

  logic        ov_r, ov_nxt;
  logic [1:0]  o_type_r;
  logic [7:0]  o_cs_r;
  logic [6:0]  o_res_r;
  logic [19:0] o_root_r;
  logic [31:0] o_cnt_r, o_flen_r, o_long_r;
  logic [15:0] o_short_r;
  logic        o_flag_r;
  logic        load_out;

  logic [12:0] ss_in;
  logic [31:0] c3;
  logic [31:0] fs;
  logic [2:0]  align_sum;
  logic        aligned;
  logic        is_small;
  logic [6:0]  res_inc;

  assign in_ready = (state_r == fvg_pkg::S_IDLE);
  assign div_done = (dcnt_r == fvg_pkg::DIV_STEPS);
  assign dtry     = {rem_r, dq_r[31]};
  assign load_out = (state_r == fvg_pkg::S_OUT) && (!ov_r || out_ready);

  always_comb begin
    if (in_sector_bytes < fvg_pkg::SECT_MIN)      ss_in = fvg_pkg::SECT_MIN;
    else if (in_sector_bytes > fvg_pkg::SECT_MAX) ss_in = fvg_pkg::SECT_MAX;
    else                                          ss_in = in_sector_bytes;
  end

  assign is_small  = (vol_r[44:29] == 16'd0) && (!vol_r[28] || (vol_r[27:0] == 28'd0));
  assign c3        = dq_r + {dq_r[30:0], 1'b0} + 32'd1;
  assign align_sum = res_r[2:0] + {dq_r[1:0], 1'b0};
  assign aligned   = (ss_r != fvg_pkg::SECT_MIN) || (align_sum == 3'd0);
  assign res_inc   = res_r + 7'd1;

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    ss_nxt    = ss_r;
    csr_nxt   = csr_r;
    cs_nxt    = cs_r;
    vol_nxt   = vol_r;
    msh_nxt   = msh_r;
    mcnt_nxt  = mcnt_r;
    small_nxt = small_r;
    cnt_nxt   = cnt_r;
    flen_nxt  = flen_r;
    res_nxt   = res_r;
    type_nxt  = type_r;
    root_nxt  = root_r;
    flag_nxt  = flag_r;
    ld        = 1'b0;
    ld_a      = 32'd0;
    ld_b      = ss_r;
    fs        = 32'd0;

    case (state_r)
      fvg_pkg::S_IDLE: begin
        if (in_valid) begin
          total_nxt = in_total_sectors;
          ss_nxt    = ss_in;
          msh_nxt   = ss_in;
          csr_nxt   = in_cluster_request;
          vol_nxt   = 45'd0;
          mcnt_nxt  = 4'd0;
          state_nxt = fvg_pkg::S_MUL;
        end
      end
      fvg_pkg::S_MUL: begin
        if (mcnt_r != fvg_pkg::MUL_STEPS) begin
          vol_nxt  = {vol_r[43:0], 1'b0} + (msh_r[12] ? {13'd0, total_r} : 45'd0);
          msh_nxt  = {msh_r[11:0], 1'b0};
          mcnt_nxt = mcnt_r + 4'd1;
        end else begin
          small_nxt = is_small;
          ld        = 1'b1;
          if (csr_r == 8'd0) begin
            ld_a      = fvg_pkg::dflt_cluster_bytes(vol_r);
            state_nxt = fvg_pkg::S_CSDIV;
          end else begin
            cs_nxt    = is_small ? 8'd1 : csr_r;
            ld_a      = {12'd0, fvg_pkg::ROOT_BYTES} + {19'd0, ss_r} - 32'd1;
            state_nxt = fvg_pkg::S_ROOT;
          end
        end
      end
      fvg_pkg::S_CSDIV: begin
        if (div_done) begin
          if (small_r || dq_r == 32'd0) cs_nxt = 8'd1;
          else if (dq_r > 32'd128)      cs_nxt = 8'd128;
          else                          cs_nxt = dq_r[7:0];
          ld        = 1'b1;
          ld_a      = {12'd0, fvg_pkg::ROOT_BYTES} + {19'd0, ss_r} - 32'd1;
          state_nxt = fvg_pkg::S_ROOT;
        end
      end
      fvg_pkg::S_ROOT: begin
        if (div_done) begin
          ld        = 1'b1;
          ld_a      = total_r - dq_r - {25'd0, fvg_pkg::RES_FAT12};
          ld_b      = {5'd0, cs_r};
          state_nxt = fvg_pkg::S_CNT;
        end
      end
      fvg_pkg::S_CNT: begin
        if (div_done) begin
          cnt_nxt   = dq_r;
          ld        = 1'b1;
          ld_a      = (c3 >> 1) + {19'd0, ss_r} - 32'd1;
          state_nxt = fvg_pkg::S_F12;
        end
      end
      fvg_pkg::S_F12: begin
        if (div_done) begin
          flen_nxt = dq_r;
          type_nxt = fvg_pkg::FAT12;
          res_nxt  = fvg_pkg::RES_FAT12;
          root_nxt = fvg_pkg::ROOT_BYTES;
          flag_nxt = 1'b0;
          ld       = 1'b1;
          if (cnt_r >= fvg_pkg::FAT12_LIMIT) begin
            type_nxt  = fvg_pkg::FAT16;
            ld_a      = {cnt_r[30:0], 1'b0} + {19'd0, ss_r} - 32'd1;
            state_nxt = fvg_pkg::S_F16;
          end else begin
            ld_a      = {dq_r[30:0], 1'b0};
            ld_b      = {5'd0, cs_r};
            state_nxt = fvg_pkg::S_SUB;
          end
        end
      end
      fvg_pkg::S_F16: begin
        if (div_done) begin
          flen_nxt = dq_r;
          ld       = 1'b1;
          ld_b     = {5'd0, cs_r};
          if (cnt_r >= fvg_pkg::FAT16_LIMIT) begin
            type_nxt  = fvg_pkg::FAT32;
            root_nxt  = 20'({12'd0, cs_r} * {7'd0, ss_r});
            res_nxt   = fvg_pkg::RES_FAT32;
            ld_a      = total_r - {25'd0, fvg_pkg::RES_FAT32};
            state_nxt = fvg_pkg::S_F32CNT;
          end else begin
            ld_a      = {dq_r[30:0], 1'b0};
            state_nxt = fvg_pkg::S_SUB;
          end
        end
      end
      fvg_pkg::S_F32CNT: begin
        if (div_done) begin
          cnt_nxt   = dq_r;
          ld        = 1'b1;
          ld_a      = {dq_r[29:0], 2'b00} + {19'd0, ss_r} - 32'd1;
          state_nxt = fvg_pkg::S_F32LEN;
        end
      end
      fvg_pkg::S_F32LEN: begin
        if (div_done) begin
          flen_nxt = dq_r;
          ld       = 1'b1;
          ld_b     = {5'd0, cs_r};
          if (!aligned && (res_r < fvg_pkg::RES_LIMIT)) begin
            res_nxt   = res_inc;
            ld_a      = total_r - {25'd0, res_inc};
            state_nxt = fvg_pkg::S_F32CNT;
          end else begin
            flag_nxt  = !aligned;
            ld_a      = {dq_r[30:0], 1'b0};
            state_nxt = fvg_pkg::S_SUB;
          end
        end
      end
      fvg_pkg::S_SUB: begin
        if (div_done) begin
          fs        = cnt_r - dq_r;
          cnt_nxt   = fs;
          state_nxt = fvg_pkg::S_OUT;
        end
      end
      fvg_pkg::S_OUT: begin
        if (load_out) state_nxt = fvg_pkg::S_IDLE;
      end
      default: state_nxt = fvg_pkg::S_IDLE;
    endcase
  end

  // one quotient bit per cycle
  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    dcnt_nxt = dcnt_r;
    if (ld) begin
      dq_nxt   = ld_a;
      rem_nxt  = 13'd0;
      dv_nxt   = ld_b;
      dcnt_nxt = 6'd0;
    end else if (!div_done) begin
      if (dtry >= {1'b0, dv_r}) begin
        rem_nxt = 13'(dtry - {1'b0, dv_r});
        dq_nxt  = {dq_r[30:0], 1'b1};
      end else begin
        rem_nxt = dtry[12:0];
        dq_nxt  = {dq_r[30:0], 1'b0};
      end
      dcnt_nxt = dcnt_r + 6'd1;
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    if (load_out) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fvg_pkg::S_IDLE;
      dcnt_r  <= fvg_pkg::DIV_STEPS;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    ss_r    <= ss_nxt;
    csr_r   <= csr_nxt;
    cs_r    <= cs_nxt;
    vol_r   <= vol_nxt;
    msh_r   <= msh_nxt;
    mcnt_r  <= mcnt_nxt;
    small_r <= small_nxt;
    cnt_r   <= cnt_nxt;
    flen_r  <= flen_nxt;
    res_r   <= res_nxt;
    type_r  <= type_nxt;
    root_r  <= root_nxt;
    flag_r  <= flag_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    dv_r    <= dv_nxt;
    if (load_out) begin
      o_type_r <= type_r;
      o_cs_r   <= cs_r;
      o_res_r  <= res_r;
      o_root_r <= root_r;
      o_cnt_r  <= cnt_r;
      o_flen_r <= flen_r;
      o_flag_r <= flag_r;
      if ((total_r >= 32'd65536) || (type_r == fvg_pkg::FAT32)) begin
        o_short_r <= 16'd0;
        o_long_r  <= total_r;
      end else begin
        o_short_r <= total_r[15:0];
        o_long_r  <= 32'd0;
      end
    end
  end

  assign out_valid               = ov_r;
  assign out_fat_type            = o_type_r;
  assign out_cluster_sectors     = o_cs_r;
  assign out_reserved_sectors    = o_res_r;
  assign out_root_dir_bytes      = o_root_r;
  assign out_cluster_count       = o_cnt_r;
  assign out_fat_sectors         = o_flen_r;
  assign out_short_total_sectors = o_short_r;
  assign out_long_total_sectors  = o_long_r;
  assign out_align_exhausted     = o_flag_r;

  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == fvg_pkg::S_MUL))
    else $error("accepted item did not start the size product");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= fvg_pkg::DIV_STEPS)
    else $error("divider step count out of range");

  a_fat32_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) && (o_type_r == fvg_pkg::FAT32) |-> (o_res_r >= fvg_pkg::RES_FAT32))
    else $error("fat32 result with too few reserved sectors");

  a_flag_only_fat32: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) && (o_type_r != fvg_pkg::FAT32) |-> !o_flag_r)
    else $error("alignment flag set outside fat32");

endmodule

FILE: bench/fat_volume_geometry_test.sv
// testbench for fat_volume_geometry: directed and random volume sizes, checked
// item by item against a behavioral geometry predictor kept in a scoreboard class
// depends on fvg_pkg and the fat_volume_geometry rtl
module fat_volume_geometry_test;

  typedef struct packed {
    fvg_pkg::fat_kind_t kind;
    logic [7:0]  clus;
    logic [6:0]  resv;
    logic [19:0] root;
    logic [31:0] count;
    logic [31:0] fatlen;
    logic [15:0] short_tot;
    logic [31:0] long_tot;
    logic        exhausted;
  } geometry_t;

  class geometry_scoreboard;
    geometry_t pending[$];
    int errors = 0;

    function geometry_t compute_geometry(logic [31:0] total, logic [12:0] sb_in,
                                         logic [7:0] req);
      logic [31:0] ss, cs, resv, root, fs, cnt, flen, tries, cb;
      logic [63:0] vol;
      bit ok;
      geometry_t g;
      ss = (sb_in < 13'd512) ? 32'd512 : (sb_in > 13'd4096) ? 32'd4096 : 32'(sb_in);
      vol = 64'(total) * 64'(ss);
      cs = 32'(req);
      if (req == 8'd0) begin
        if (vol >= 64'd1 << 41) cb = 262144;
        else if (vol >= 64'd1 << 39) cb = 131072;
        else if (vol >= 64'd1 << 37) cb = 65536;
        else if (vol >= 64'd1 << 36) cb = 32768;
        else if (vol >= 64'd1 << 35) cb = 16384;
        else if (vol >= 64'd1 << 34) cb = 8192;
        else if (vol >= 64'd1 << 29) cb = 4096;
        else if (vol >= 64'd1 << 28) cb = 2048;
        else if (vol >= 64'd1 << 20) cb = 1024;
        else cb = 512;
        cs = cb / ss;
        if (cs == 0) cs = 1;
        if (64'(cs) * 64'(ss) > 64'd67108864) cs = 32'd67108864 / ss;
        if (cs > 128) cs = 128;
      end
      if (vol <= 64'd268435456) cs = 1;
      g.kind = fvg_pkg::FAT12;
      g.exhausted = 1'b0;
      resv = 2;
      root = 16384;
      fs = total - (root + ss - 32'd1) / ss - resv;
      cnt = fs / cs;
      flen = (((cnt * 32'd3 + 32'd1) >> 1) + ss - 32'd1) / ss;
      if (cnt >= 32'd4085) begin
        g.kind = fvg_pkg::FAT16;
        flen = (cnt * 32'd2 + ss - 32'd1) / ss;
      end
      if (cnt >= 32'd65525) begin
        g.kind = fvg_pkg::FAT32;
        root = cs * ss;
        resv = 31;
        tries = 0;
        do begin
          resv++;
          tries++;
          cnt = (total - resv) / cs;
          flen = (cnt * 32'd4 + ss - 32'd1) / ss;
          ok = (ss != 512) || (((resv + flen * 32'd2) & 32'd7) == 0);
        end while (!ok && tries < fvg_pkg::MAX_ALIGN_TRIES);
        g.exhausted = !ok;
      end
      cnt = cnt - (flen * 32'd2) / cs;
      g.clus = cs[7:0];
      g.resv = resv[6:0];
      g.root = root[19:0];
      g.count = cnt;
      g.fatlen = flen;
      if (total >= 32'd65536 || g.kind == fvg_pkg::FAT32) begin
        g.short_tot = 16'd0;
        g.long_tot = total;
      end else begin
        g.short_tot = total[15:0];
        g.long_tot = 32'd0;
      end
      return g;
    endfunction

    function void note_request(logic [31:0] total, logic [12:0] sb, logic [7:0] req);
      pending.push_back(compute_geometry(total, sb, req));
    endfunction

    function void check_result(geometry_t got);
      geometry_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [31:0] in_total_sectors;
  logic [12:0] in_sector_bytes;
  logic [7:0]  in_cluster_request;
  geometry_t   res;
  logic [1:0]  out_fat_type;
  logic [7:0]  out_cluster_sectors;
  logic [6:0]  out_reserved_sectors;
  logic [19:0] out_root_dir_bytes;
  logic [31:0] out_cluster_count;
  logic [31:0] out_fat_sectors;
  logic [15:0] out_short_total_sectors;
  logic [31:0] out_long_total_sectors;
  logic        out_align_exhausted;

  geometry_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit hold_now = 1'b0;

  fat_volume_geometry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_total_sectors(in_total_sectors), .in_sector_bytes(in_sector_bytes),
    .in_cluster_request(in_cluster_request),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fat_type(out_fat_type), .out_cluster_sectors(out_cluster_sectors),
    .out_reserved_sectors(out_reserved_sectors), .out_root_dir_bytes(out_root_dir_bytes),
    .out_cluster_count(out_cluster_count), .out_fat_sectors(out_fat_sectors),
    .out_short_total_sectors(out_short_total_sectors),
    .out_long_total_sectors(out_long_total_sectors),
    .out_align_exhausted(out_align_exhausted)
  );
  assign res = {out_fat_type, out_cluster_sectors, out_reserved_sectors,
                out_root_dir_bytes, out_cluster_count, out_fat_sectors,
                out_short_total_sectors, out_long_total_sectors, out_align_exhausted};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_total_sectors, in_sector_bytes, in_cluster_request);
    if (rst_n && out_valid && out_ready)
      sb.check_result(res);
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now) begin
        out_ready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_now = 1'b0;
      end else begin
        out_ready <= gaps_on ? ($urandom_range(99) >= 17) : 1'b1;
      end
    end
  end

  task automatic send_item(logic [31:0] total, logic [12:0] sbytes, logic [7:0] req);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_total_sectors <= total;
    in_sector_bytes <= sbytes;
    in_cluster_request <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_total();
    case ($urandom_range(5))
      0: return $urandom_range(70000);
      1: return $urandom_range(32'h0040_0000);
      2: return $urandom_range(32'h0800_0000);
      3: return $urandom();
      4: return 32'd4085 * $urandom_range(1, 130) + $urandom_range(40) - 20;
      default: return 32'd65525 * $urandom_range(1, 200) + $urandom_range(200);
    endcase
  endfunction

  function automatic logic [12:0] pick_sector();
    if ($urandom_range(9) < 8) return 13'd512 << $urandom_range(3);
    return 13'($urandom_range(13'h1fff));
  endfunction

  function automatic logic [7:0] pick_request();
    case ($urandom_range(3))
      0, 1: return 8'd0;
      2: return 8'd1 << $urandom_range(7);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_total_sectors = '0;
    in_sector_bytes = 13'd512;
    in_cluster_request = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes, type boundaries, clamped and odd sector sizes
    send_item(32'd0, 13'd512, 8'd0);
    send_item(32'd1, 13'd512, 8'd1);
    send_item(32'hffff_ffff, 13'd512, 8'd0);
    send_item(32'hffff_ffff, 13'd4096, 8'd0);
    send_item(32'hffff_ffff, 13'd4096, 8'd255);
    send_item(32'd65535, 13'd512, 8'd0);
    send_item(32'd65536, 13'd512, 8'd0);
    send_item(32'd4085 + 32'd34, 13'd512, 8'd1);
    send_item(32'd4084 + 32'd34, 13'd512, 8'd1);
    send_item(32'd65525 + 32'd200, 13'd512, 8'd1);
    send_item(32'd524288, 13'd512, 8'd0);
    send_item(32'd524289, 13'd512, 8'd0);
    send_item(32'd2000000, 13'd512, 8'd128);
    send_item(32'd3000000, 13'd1000, 8'd3);
    send_item(32'd3000000, 13'd0, 8'd0);
    send_item(32'd3000000, 13'h1fff, 8'd0);
    send_item(32'h8000_0000, 13'd2048, 8'd0);
    send_item(32'h1000_0000, 13'd512, 8'd64);
    send_item(32'd20, 13'd4096, 8'd0);

    // long stretch without idling on either side
    gaps_on = 1'b0;
    repeat (40) send_item(pick_total(), pick_sector(), pick_request());
    gaps_on = 1'b1;
    hold_now = 1'b1;
    repeat (360) send_item(pick_total(), pick_sector(), pick_request());
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
